// File: rtl/vg3_pkg.sv
package vg3_pkg;

  // volume limits
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_DEPTH  = 128;

  // voxel history: two planes, two lines and three voxels
  localparam int STORE_DEPTH = 2 * MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // position counters
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int SLICE_W = $clog2(MAX_DEPTH);
  localparam int AREA_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  // configuration port
  localparam int SIZE_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SIZE_W;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_HEIGHT = 2'd1;
  localparam logic [SIZE_W-1:0]    MIN_SIZE         = 7'd3;
  localparam logic [SIZE_W-1:0]    MAX_W_SIZE       = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0]    MAX_H_SIZE       = SIZE_W'(MAX_HEIGHT);

  // sample and stored word: three consecutive voxels, newest in the top slot
  localparam int VOX_W  = 16;
  localparam int WORD_W = 3 * VOX_W;

  // window rows (dy, dz pairs); row 0 is the live row, the rest come from memory
  localparam int ROWS     = 9;
  localparam int MEM_ROWS = ROWS - 1;
  localparam int NBANK    = MEM_ROWS / 2;

  // arithmetic widths
  localparam int DIFF_W = VOX_W + 1;
  localparam int GRP_W  = DIFF_W + 2;
  localparam int WT_W   = 16;
  localparam int ACC_W  = GRP_W + WT_W + 2;
  localparam int GRAD_W = 24;

  // Q1.15 weights, rounding to 4 fraction bits
  localparam int FACE_SHIFT = 15;
  localparam logic signed [WT_W-1:0] W_EDGE   = 16'sd23170;
  localparam logic signed [WT_W-1:0] W_CORNER = 16'sd18919;
  localparam int FRAC_DROP  = 11;
  localparam logic signed [ACC_W-1:0] ROUND_ADD = ACC_W'(1 << (FRAC_DROP - 1));

  // centre position travelling with a request
  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [SLICE_W-1:0] slice;
  } pos_t;

endpackage

// File: rtl/vg3_in_if.sv
interface vg3_in_if import vg3_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VOX_W-1:0] voxel;
  logic                    volume_start;

  modport source (output valid, voxel, volume_start, input ready);
  modport sink   (input valid, voxel, volume_start, output ready);
endinterface

// File: rtl/vg3_out_if.sv
interface vg3_out_if import vg3_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic signed [GRAD_W-1:0] grad_z;
  logic [COL_W-1:0]         centre_col;
  logic [ROW_W-1:0]         centre_row;
  logic [SLICE_W-1:0]       centre_slice;

  modport source (output valid, grad_x, grad_y, grad_z, centre_col, centre_row,
                  centre_slice, input ready);
  modport sink   (input valid, grad_x, grad_y, grad_z, centre_col, centre_row,
                  centre_slice, output ready);
endinterface

// File: rtl/volume_gradient_3x3x3_core.sv
// channel   | dir | handshake          | payload
// in_ch     | in  | valid/ready        | voxel, volume_start
// out_ch    | out | valid/ready        | grad_x/y/z, centre_col/row/slice
// cfg       | in  | cfg_we, no ready   | cfg_index, cfg_wdata (line_width, plane_height)
//
// one voxel per cycle is accepted while in_ch.ready is high; a completed window passes the
// stage registers in order and then the output register. the eight older window rows are read
// each cycle from four identical copies of the voxel history, two read ports each, one write per accepted voxel.
// reset needs no clearing pass: a fill count marks history older than the first write as zero.
// a stall on out_ch holds each full stage; the input also waits while a request sits before
// its history read, so no later write can overwrite a row that request still needs.
module volume_gradient_3x3x3_core import vg3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  vg3_in_if.sink                in_ch,
  vg3_out_if.source             out_ch
);

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] res;
    if (v < MIN_SIZE) begin
      res = MIN_SIZE;
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // size registers, held clamped
  logic [SIZE_W-1:0]         w_r, h_r;
  logic [AREA_W-1:0]         wh_r;
  logic [2*SIZE_W-1:0]       wh_prod;

  // stream position and history
  logic [COL_W-1:0]          col_r;
  logic [ROW_W-1:0]          row_r;
  logic [SLICE_W-1:0]        slice_r;
  logic [ADDR_W-1:0]         wr_ptr_r, fill_r;
  logic signed [VOX_W-1:0]   hist1_r, hist2_r;

  // accept-side logic
  logic                      in_acc;
  logic [COL_W-1:0]          x_cur;
  logic [ROW_W-1:0]          y_cur;
  logic [SLICE_W-1:0]        z_cur;
  logic                      res_hit, col_wrap, row_wrap, slice_wrap;
  logic [COL_W-1:0]          col_nxt;
  logic [ROW_W-1:0]          row_nxt;
  logic [SLICE_W-1:0]        slice_nxt;
  logic [WORD_W-1:0]         wr_word;
  pos_t                      pos_nxt;

  // stage ready chain
  logic                      rdy0, rdy1, rdy2, rdy3, rdy4, rdy5;

  // stage 0: accepted request with a result
  logic                      v0_r;
  logic [ADDR_W-1:0]         s0_ptr_r, s0_fill_r;
  logic [WORD_W-1:0]         s0_word_r;
  pos_t                      s0_pos_r;

  // stage 1: read addresses
  logic                      v1_r;
  logic [ADDR_W-1:0]         off [ROWS];
  logic [ADDR_W:0]           diff_addr [MEM_ROWS];
  logic [ADDR_W-1:0]         addr_nxt [MEM_ROWS];
  logic [MEM_ROWS-1:0]       rowv_nxt;
  logic [ADDR_W-1:0]         s1_addr_r [MEM_ROWS];
  logic [MEM_ROWS-1:0]       s1_rowv_r;
  logic [WORD_W-1:0]         s1_word_r;
  pos_t                      s1_pos_r;

  // stage 2: window rows
  logic                      v2_r;
  logic [WORD_W-1:0]         rd_word [MEM_ROWS];
  logic [MEM_ROWS-1:0]       s2_rowv_r;
  logic [WORD_W-1:0]         s2_word_r;
  pos_t                      s2_pos_r;
  logic [WORD_W-1:0]         row_w [ROWS];
  logic signed [VOX_W-1:0]   samp [3][3][3];
  logic signed [DIFF_W-1:0]  face_nxt [3];
  logic signed [GRP_W-1:0]   edge_nxt [3];
  logic signed [GRP_W-1:0]   corner_nxt [3];

  // stage 3: grouped differences
  logic                      v3_r;
  logic signed [DIFF_W-1:0]  s3_face_r [3];
  logic signed [GRP_W-1:0]   s3_edge_r [3];
  logic signed [GRP_W-1:0]   s3_corner_r [3];
  pos_t                      s3_pos_r;

  // stage 4: weighted terms
  logic                      v4_r;
  logic signed [ACC_W-1:0]   s4_face_r [3];
  logic signed [ACC_W-1:0]   s4_edge_r [3];
  logic signed [ACC_W-1:0]   s4_corner_r [3];
  pos_t                      s4_pos_r;

  // output register
  logic                      out_v_r;
  logic signed [ACC_W-1:0]   acc_sum [3];
  logic signed [ACC_W-1:0]   acc_shr [3];
  logic signed [GRAD_W-1:0]  grad_r [3];
  pos_t                      out_pos_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= MAX_W_SIZE;
      h_r <= MAX_H_SIZE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_WIDTH:   w_r <= clamp_size(cfg_wdata, MAX_W_SIZE);
        REG_PLANE_HEIGHT: h_r <= clamp_size(cfg_wdata, MAX_H_SIZE);
        default: ;
      endcase
    end
  end

  // plane area
  assign wh_prod = w_r * h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wh_r <= AREA_W'(MAX_WIDTH * MAX_HEIGHT);
    end else begin
      wh_r <= wh_prod[AREA_W-1:0];
    end
  end

  // handshake chain
  assign rdy5 = !out_v_r || out_ch.ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign rdy0 = !v0_r || rdy1;

  // no write while a request waits in stage 1 for its history read
  assign in_ch.ready = rdy1;
  assign in_acc      = in_ch.valid && rdy1;

  // position of the incoming voxel and the next position
  always_comb begin
    x_cur      = in_ch.volume_start ? '0 : col_r;
    y_cur      = in_ch.volume_start ? '0 : row_r;
    z_cur      = in_ch.volume_start ? '0 : slice_r;
    res_hit    = (x_cur >= COL_W'(2)) && (y_cur >= ROW_W'(2)) && (z_cur >= SLICE_W'(2));
    col_wrap   = (SIZE_W'(x_cur) + SIZE_W'(1)) >= w_r;
    row_wrap   = (SIZE_W'(y_cur) + SIZE_W'(1)) >= h_r;
    slice_wrap = z_cur == SLICE_W'(MAX_DEPTH - 1);
    col_nxt    = col_wrap ? '0 : x_cur + COL_W'(1);
    row_nxt    = y_cur;
    slice_nxt  = z_cur;
    if (col_wrap) begin
      row_nxt = row_wrap ? '0 : y_cur + ROW_W'(1);
      if (row_wrap) begin
        slice_nxt = slice_wrap ? '0 : z_cur + SLICE_W'(1);
      end
    end
    pos_nxt.col   = x_cur - COL_W'(1);
    pos_nxt.row   = y_cur - ROW_W'(1);
    pos_nxt.slice = z_cur - SLICE_W'(1);
    wr_word       = {in_ch.voxel, hist1_r, hist2_r};
  end

  // counters, write pointer, fill count, recent voxels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      slice_r  <= '0;
      wr_ptr_r <= '0;
      fill_r   <= '0;
      hist1_r  <= '0;
      hist2_r  <= '0;
    end else if (in_acc) begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      slice_r  <= slice_nxt;
      wr_ptr_r <= (wr_ptr_r == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wr_ptr_r + ADDR_W'(1);
      fill_r   <= (fill_r == ADDR_W'(STORE_DEPTH - 1)) ? fill_r : fill_r + ADDR_W'(1);
      hist1_r  <= in_ch.voxel;
      hist2_r  <= hist1_r;
    end
  end

  // stage 0 capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (rdy0) begin
      v0_r <= in_acc && res_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_ptr_r  <= wr_ptr_r;
      s0_fill_r <= fill_r;
      s0_word_r <= wr_word;
      s0_pos_r  <= pos_nxt;
    end
  end

  // row offsets back into the history and their addresses
  always_comb begin
    for (int zi = 0; zi < 3; zi++) begin
      for (int yi = 0; yi < 3; yi++) begin
        off[zi*3+yi] = ADDR_W'(yi) * ADDR_W'(w_r) + ADDR_W'(zi) * ADDR_W'(wh_r);
      end
    end
    for (int m = 0; m < MEM_ROWS; m++) begin
      diff_addr[m] = {1'b0, s0_ptr_r} - {1'b0, off[m+1]};
      addr_nxt[m]  = diff_addr[m][ADDR_W] ? diff_addr[m][ADDR_W-1:0] + ADDR_W'(STORE_DEPTH)
                                          : diff_addr[m][ADDR_W-1:0];
      rowv_nxt[m]  = off[m+1] <= s0_fill_r;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_addr_r <= addr_nxt;
      s1_rowv_r <= rowv_nxt;
      s1_word_r <= s0_word_r;
      s1_pos_r  <= s0_pos_r;
    end
  end

  // history copies, two rows read from each
  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    logic [WORD_W-1:0] mem_r [STORE_DEPTH];
    logic [WORD_W-1:0] rd0_r, rd1_r;

    always_ff @(posedge clk) begin
      if (in_acc) begin
        mem_r[wr_ptr_r] <= wr_word;
      end
      if (rdy2) begin
        rd0_r <= mem_r[s1_addr_r[2*b]];
        rd1_r <= mem_r[s1_addr_r[2*b+1]];
      end
    end

    assign rd_word[2*b]   = rd0_r;
    assign rd_word[2*b+1] = rd1_r;
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_rowv_r <= s1_rowv_r;
      s2_word_r <= s1_word_r;
      s2_pos_r  <= s1_pos_r;
    end
  end

  // unpack the 27 samples, history not yet written reads as zero
  always_comb begin
    row_w[0] = s2_word_r;
    for (int m = 0; m < MEM_ROWS; m++) begin
      row_w[m+1] = s2_rowv_r[m] ? rd_word[m] : '0;
    end
    for (int zi = 0; zi < 3; zi++) begin
      for (int yi = 0; yi < 3; yi++) begin
        for (int xi = 0; xi < 3; xi++) begin
          samp[zi][yi][xi] = row_w[zi*3+yi][VOX_W*(2-xi) +: VOX_W];
        end
      end
    end
  end

  // central differences per axis, grouped by weight
  always_comb begin
    logic signed [DIFF_W-1:0] d [3];
    for (int a = 0; a < 3; a++) begin
      face_nxt[a]   = '0;
      edge_nxt[a]   = '0;
      corner_nxt[a] = '0;
    end
    for (int ai = 0; ai < 3; ai++) begin
      for (int bi = 0; bi < 3; bi++) begin
        d[0] = DIFF_W'(samp[bi][ai][0]) - DIFF_W'(samp[bi][ai][2]);
        d[1] = DIFF_W'(samp[bi][0][ai]) - DIFF_W'(samp[bi][2][ai]);
        d[2] = DIFF_W'(samp[0][bi][ai]) - DIFF_W'(samp[2][bi][ai]);
        for (int a = 0; a < 3; a++) begin
          if (ai == 1 && bi == 1) begin
            face_nxt[a] = d[a];
          end else if (ai == 1 || bi == 1) begin
            edge_nxt[a] = edge_nxt[a] + GRP_W'(d[a]);
          end else begin
            corner_nxt[a] = corner_nxt[a] + GRP_W'(d[a]);
          end
        end
      end
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_face_r   <= face_nxt;
      s3_edge_r   <= edge_nxt;
      s3_corner_r <= corner_nxt;
      s3_pos_r    <= s2_pos_r;
    end
  end

  // stage 4: weights applied
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int a = 0; a < 3; a++) begin
        s4_face_r[a]   <= ACC_W'(s3_face_r[a]) <<< FACE_SHIFT;
        s4_edge_r[a]   <= ACC_W'(s3_edge_r[a]) * ACC_W'(W_EDGE);
        s4_corner_r[a] <= ACC_W'(s3_corner_r[a]) * ACC_W'(W_CORNER);
      end
      s4_pos_r <= s3_pos_r;
    end
  end

  // final sum, round half up to 4 fraction bits
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      acc_sum[a] = s4_face_r[a] + s4_edge_r[a] + s4_corner_r[a] + ROUND_ADD;
      acc_shr[a] = acc_sum[a] >>> FRAC_DROP;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy5) begin
      out_v_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      for (int a = 0; a < 3; a++) begin
        grad_r[a] <= acc_shr[a][GRAD_W-1:0];
      end
      out_pos_r <= s4_pos_r;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.grad_x       = grad_r[0];
  assign out_ch.grad_y       = grad_r[1];
  assign out_ch.grad_z       = grad_r[2];
  assign out_ch.centre_col   = out_pos_r.col;
  assign out_ch.centre_row   = out_pos_r.row;
  assign out_ch.centre_slice = out_pos_r.slice;

endmodule

// File: dv/volume_gradient_3x3x3_core_tb.sv
module volume_gradient_3x3x3_core_tb;
  import vg3_pkg::*;

  // run control
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_AT      = 60;
  localparam int HOLD_LEN     = 400;
  localparam int REPORT_MAX   = 10;

  // unused register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // zucker-hummel weights in q1.15, rounding to 4 fraction bits
  localparam longint ZH_FACE   = 32768;
  localparam longint ZH_EDGE   = 23170;
  localparam longint ZH_CORNER = 18919;
  localparam longint HALF_LSB  = longint'(1) << (FRAC_DROP - 1);

  typedef struct {
    logic [VOX_W-1:0] voxel;
    logic             start;
  } voxel_req_t;

  typedef struct packed {
    logic [GRAD_W-1:0]  gx;
    logic [GRAD_W-1:0]  gy;
    logic [GRAD_W-1:0]  gz;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [SLICE_W-1:0] slice;
  } grad_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  vg3_in_if  in_ch ();
  vg3_out_if out_ch ();

  volume_gradient_3x3x3_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor state: voxel history, position of the next voxel, sizes
  logic [VOX_W-1:0]  hist [STORE_DEPTH];
  int                hist_ptr;
  int                nx_col;
  int                nx_row;
  int                nx_slice;
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;

  voxel_req_t   voxel_q [$];
  grad_result_t pending_grads [$];
  voxel_req_t   next_req;

  int voxels_queued;
  int voxels_taken;
  int grads_seen;
  int bad_count;
  int cycle_cnt;
  int send_gap;
  int send_calm;
  int take_gap;
  int take_calm;
  int hold_left;

  // clock and known input levels from time zero
  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.voxel         = '0;
    in_ch.volume_start  = 1'b0;
    out_ch.ready        = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int clamp_size(logic [SIZE_W-1:0] v, int hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  // sample at offset (dx,dy,dz) from the centre, newest voxel already written
  function automatic longint hist_at(int dx, int dy, int dz, int w, int wh);
    int back;
    int idx;
    back = (1 - dx) + (1 - dy) * w + (1 - dz) * wh;
    idx  = hist_ptr + STORE_DEPTH - back;
    if (idx >= STORE_DEPTH) idx -= STORE_DEPTH;
    return longint'($signed(hist[idx]));
  endfunction

  function automatic longint zh_weight(int a, int b);
    int n;
    n = (a != 0) + (b != 0);
    if (n == 0) return ZH_FACE;
    if (n == 1) return ZH_EDGE;
    return ZH_CORNER;
  endfunction

  // round half up to 4 fraction bits
  function automatic logic [GRAD_W-1:0] round_grad(longint acc);
    longint q;
    q = (acc + HALF_LSB) >>> FRAC_DROP;
    return q[GRAD_W-1:0];
  endfunction

  // one accepted voxel: store it, emit a gradient for an interior centre, advance
  function automatic void zh_gradient_step(logic [VOX_W-1:0] vox, logic start);
    int           w, h, wh, x, y, z, a, b;
    longint       gx, gy, gz, wt;
    grad_result_t r;
    w  = clamp_size(width_reg, MAX_WIDTH);
    h  = clamp_size(height_reg, MAX_HEIGHT);
    wh = w * h;
    if (start) begin
      nx_col   = 0;
      nx_row   = 0;
      nx_slice = 0;
    end
    x = nx_col;
    y = nx_row;
    z = nx_slice;
    hist[hist_ptr] = vox;
    if (x >= 2 && y >= 2 && z >= 2) begin
      gx = 0;
      gy = 0;
      gz = 0;
      for (a = -1; a <= 1; a++) begin
        for (b = -1; b <= 1; b++) begin
          wt = zh_weight(a, b);
          gx += wt * (hist_at(1, a, b, w, wh) - hist_at(-1, a, b, w, wh));
          gy += wt * (hist_at(a, 1, b, w, wh) - hist_at(a, -1, b, w, wh));
          gz += wt * (hist_at(a, b, 1, w, wh) - hist_at(a, b, -1, w, wh));
        end
      end
      r.gx    = round_grad(gx);
      r.gy    = round_grad(gy);
      r.gz    = round_grad(gz);
      r.col   = COL_W'(x - 1);
      r.row   = ROW_W'(y - 1);
      r.slice = SLICE_W'(z - 1);
      pending_grads.push_back(r);
    end
    hist_ptr = (hist_ptr + 1 >= STORE_DEPTH) ? 0 : hist_ptr + 1;
    if (nx_col + 1 >= w) begin
      nx_col = 0;
      if (nx_row + 1 >= h) begin
        nx_row   = 0;
        nx_slice = (nx_slice + 1 >= MAX_DEPTH) ? 0 : nx_slice + 1;
      end else
        nx_row++;
    end else
      nx_col++;
  endfunction

  // gap length: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // sample values weighted toward the extremes and near zero
  function automatic logic [VOX_W-1:0] rand_voxel();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return VOX_W'($urandom_range(0, 15) - 8);
      default: return VOX_W'($urandom);
    endcase
  endfunction

  function automatic void check_grad();
    grad_result_t got;
    grad_result_t want;
    got.gx    = out_ch.grad_x;
    got.gy    = out_ch.grad_y;
    got.gz    = out_ch.grad_z;
    got.col   = out_ch.centre_col;
    got.row   = out_ch.centre_row;
    got.slice = out_ch.centre_slice;
    if (pending_grads.size() == 0) begin
      bad_count++;
      if (bad_count <= REPORT_MAX)
        $display("unexpected gradient at (%0d,%0d,%0d): %0d %0d %0d", got.col, got.row,
                 got.slice, $signed(got.gx), $signed(got.gy), $signed(got.gz));
    end else begin
      want = pending_grads.pop_front();
      if (got !== want) begin
        bad_count++;
        if (bad_count <= REPORT_MAX)
          $display("gradient mismatch: exp (%0d,%0d,%0d) %0d %0d %0d, got (%0d,%0d,%0d) %0d %0d %0d",
                   want.col, want.row, want.slice,
                   $signed(want.gx), $signed(want.gy), $signed(want.gz),
                   got.col, got.row, got.slice,
                   $signed(got.gx), $signed(got.gy), $signed(got.gz));
      end
    end
  endfunction

  task automatic push_voxel(logic [VOX_W-1:0] v, logic s);
    voxel_req_t q;
    q.voxel = v;
    q.start = s;
    voxel_q.push_back(q);
    voxels_queued++;
  endtask

  task automatic queue_noise(int n, logic start_first);
    int i;
    for (i = 0; i < n; i++) push_voxel(rand_voxel(), start_first && i == 0);
  endtask

  // register write, mirrored into the predictor
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == REG_LINE_WIDTH) width_reg = data;
    else if (idx == REG_PLANE_HEIGHT) height_reg = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // all requests taken, all gradients back, pipeline flushed
  task automatic wait_idle();
    while (voxels_taken != voxels_queued || pending_grads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // input driver: one request per handshake, random gaps and calm stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        zh_gradient_step(in_ch.voxel, in_ch.volume_start);
        voxels_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0 || voxel_q.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_ch.valid <= 1'b0;
        end else begin
          next_req = voxel_q.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.voxel        <= next_req.voxel;
          in_ch.volume_start <= next_req.start;
          if (send_calm > 0) begin
            send_calm--;
            send_gap = 0;
          end else begin
            send_gap = idle_len();
            if ($urandom_range(0, 24) == 0) send_calm = $urandom_range(20, 80);
          end
        end
      end
    end
  end

  // result monitor with random back-pressure and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_grad();
        grads_seen++;
        if (grads_seen == HOLD_AT) hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (take_calm > 0)
          take_calm--;
        else begin
          take_gap = idle_len();
          if ($urandom_range(0, 19) == 0) take_calm = $urandom_range(20, 80);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int x, y, z, i, k, n, len, per;
    logic [VOX_W-1:0] v;
    for (i = 0; i < STORE_DEPTH; i++) hist[i] = '0;
    hist_ptr   = 0;
    nx_col     = 0;
    nx_row     = 0;
    nx_slice   = 0;
    width_reg  = SIZE_W'(MAX_WIDTH);
    height_reg = SIZE_W'(MAX_HEIGHT);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // smallest volume, full-scale x ramp: largest gradient magnitude
    write_cfg(REG_LINE_WIDTH, 7'd3);
    write_cfg(REG_PLANE_HEIGHT, 7'd3);
    for (z = 0; z < 3; z++) begin
      for (y = 0; y < 3; y++) begin
        for (x = 0; x < 3; x++) begin
          v = (x == 0) ? 16'h8000 : (x == 2) ? 16'h7fff : 16'hffff;
          push_voxel(v, x == 0 && y == 0 && z == 0);
        end
      end
    end
    wait_idle();

    // writes to unused indexes are dropped
    write_cfg(REG_SPARE_2, 7'd5);
    write_cfg(REG_SPARE_3, 7'd127);

    // sizes below range clamp to 3; run past the deepest slice so it wraps
    write_cfg(REG_LINE_WIDTH, 7'd0);
    write_cfg(REG_PLANE_HEIGHT, 7'd2);
    queue_noise(9 * (MAX_DEPTH + 3), 1'b1);
    wait_idle();

    // size changes inside one volume
    write_cfg(REG_PLANE_HEIGHT, 7'd1);
    queue_noise(18, 1'b1);
    wait_idle();
    write_cfg(REG_PLANE_HEIGHT, SIZE_W'(MAX_HEIGHT));
    queue_noise(3 * MAX_HEIGHT, 1'b0);
    wait_idle();
    queue_noise(3 * 30, 1'b0);
    wait_idle();
    // row counter now beyond the new height
    write_cfg(REG_PLANE_HEIGHT, 7'd5);
    queue_noise(12, 1'b0);
    wait_idle();
    write_cfg(REG_LINE_WIDTH, 7'd127);
    write_cfg(REG_PLANE_HEIGHT, 7'd3);
    queue_noise(3 * MAX_WIDTH, 1'b0);
    wait_idle();

    // random volumes, some cut short, some restarted midway
    for (k = 0; k < 3; k++) begin
      write_cfg(REG_LINE_WIDTH, CFG_DATA_W'($urandom_range(3, 7)));
      write_cfg(REG_PLANE_HEIGHT, CFG_DATA_W'($urandom_range(3, 5)));
      per = clamp_size(width_reg, MAX_WIDTH) * clamp_size(height_reg, MAX_HEIGHT);
      n   = 0;
      while (n < 90) begin
        len = per * $urandom_range(3, 4);
        if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len - 1);
        for (i = 0; i < len; i++)
          push_voxel(rand_voxel(), i == 0 || $urandom_range(0, 99) == 0);
        n += len;
      end
      wait_idle();
    end

    if (bad_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: volume_gradient_3x3x3_core.f
rtl/vg3_pkg.sv
rtl/vg3_in_if.sv
rtl/vg3_out_if.sv
rtl/volume_gradient_3x3x3_core.sv
dv/volume_gradient_3x3x3_core_tb.sv
